/* rtl/etok_pkg.sv */
`timescale 1ns / 1ps
// Expression tokenizer package: word types, codes, character classes and helpers.
package etok_pkg;

	// Field widths of the result word
	localparam int TYPE_W = 4;
	localparam int POS_W  = 11;
	localparam int ERR_W  = 2;

	// Depth of the result queue
	localparam int OUTQ_DEPTH = 4;

	// Input word kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	// Token types
	localparam logic [TYPE_W-1:0] TT_END    = 4'd0;
	localparam logic [TYPE_W-1:0] TT_NUMBER = 4'd1;
	localparam logic [TYPE_W-1:0] TT_IDENT  = 4'd2;
	localparam logic [TYPE_W-1:0] TT_STRING = 4'd3;
	localparam logic [TYPE_W-1:0] TT_LPAREN = 4'd4;
	localparam logic [TYPE_W-1:0] TT_RPAREN = 4'd5;
	localparam logic [TYPE_W-1:0] TT_LBRACK = 4'd6;
	localparam logic [TYPE_W-1:0] TT_RBRACK = 4'd7;
	localparam logic [TYPE_W-1:0] TT_COMMA  = 4'd8;
	localparam logic [TYPE_W-1:0] TT_COLON  = 4'd9;
	localparam logic [TYPE_W-1:0] TT_EQUAL  = 4'd10;
	localparam logic [TYPE_W-1:0] TT_OPER   = 4'd11;
	localparam logic [TYPE_W-1:0] TT_ERROR  = 4'd12;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNTERM  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_TOOLONG = 2'd2;

	// Characters with a role of their own
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7c;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_UC_X   = 8'h58;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_UC_B   = 8'h42;
	localparam logic [7:0] CH_LC_O   = 8'h6f;
	localparam logic [7:0] CH_UC_O   = 8'h4f;
	localparam logic [7:0] CH_LC_E   = 8'h65;
	localparam logic [7:0] CH_UC_E   = 8'h45;
	localparam logic [7:0] CH_LC_I   = 8'h69;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	// Scanner modes
	typedef enum logic [11:0] {
		M_IDLE   = 12'b0000_0000_0001,
		M_IDENT  = 12'b0000_0000_0010,
		M_ZERO   = 12'b0000_0000_0100,
		M_INT    = 12'b0000_0000_1000,
		M_FRAC   = 12'b0000_0001_0000,
		M_EXP    = 12'b0000_0010_0000,
		M_EXPD   = 12'b0000_0100_0000,
		M_HEX    = 12'b0000_1000_0000,
		M_STR    = 12'b0001_0000_0000,
		M_STRESC = 12'b0010_0000_0000,
		M_DOT    = 12'b0100_0000_0000,
		M_OP     = 12'b1000_0000_0000
	} scan_mode_t;

	// Input word
	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [TYPE_W-1:0] token_type;
		logic [POS_W-1:0]  token_start;
		logic [POS_W-1:0]  token_length;
		logic [ERR_W-1:0]  error_code;
		logic              line_done;
		logic              run_last;
	} out_word_t;

	// Up to two results caused by one input word
	typedef struct packed {
		logic [1:0] count;
		out_word_t  w0;
		out_word_t  w1;
	} res_pair_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return is_alpha(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_id_cont(input logic [7:0] c);
		return is_id_start(c) || is_digit(c);
	endfunction

	function automatic out_word_t mk_word(input logic [TYPE_W-1:0] t,
			input logic [POS_W-1:0] start, input logic [POS_W-1:0] len,
			input logic [ERR_W-1:0] err, input logic done);
		out_word_t w;
		w.token_type   = t;
		w.token_start  = start;
		w.token_length = len;
		w.error_code   = err;
		w.line_done    = done;
		w.run_last     = 1'b0;
		return w;
	endfunction

endpackage

/* rtl/etok_lexer.sv */
`timescale 1ns / 1ps
// Scanner: line state registers and the per-character token logic.
module etok_lexer #(
	parameter int MAX_LINE_LEN = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  etok_pkg::in_word_t item,
	output etok_pkg::res_pair_t res
);

	localparam int PW = $clog2(MAX_LINE_LEN + 1);
	localparam logic [PW-1:0] LINE_MAX = PW'(MAX_LINE_LEN);
	localparam logic [etok_pkg::POS_W-1:0] LEN_MAX_OUT = etok_pkg::POS_W'(MAX_LINE_LEN);

	etok_pkg::scan_mode_t mode_q, mode_d;
	logic [PW-1:0] beg_q, beg_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [7:0]    held_q, held_d;
	logic          ovf_q, ovf_d;

	// Candidate results
	logic                 cl_v, bg_v, a_v, b_v, fall;
	etok_pkg::out_word_t  cl_r, bg_r, a_r, b_r;
	etok_pkg::scan_mode_t bg_mode;
	logic [PW-1:0]        bg_beg;
	logic [7:0]           bg_held;
	logic [7:0]           c;
	logic [etok_pkg::POS_W-1:0] pos_o, beg_o, len_open, len_incl;

	assign c        = item.ch;
	assign pos_o    = etok_pkg::POS_W'(pos_q);
	assign beg_o    = etok_pkg::POS_W'(beg_q);
	assign len_open = etok_pkg::POS_W'(pos_q - beg_q);
	assign len_incl = etok_pkg::POS_W'(pos_q + PW'(1) - beg_q);

	// Token closed by the current position
	always_comb begin
		cl_v = 1'b1;
		cl_r = etok_pkg::mk_word(etok_pkg::TT_IDENT, beg_o, len_open,
			etok_pkg::ERR_NONE, 1'b0);
		case (mode_q)
			etok_pkg::M_IDENT: begin
				cl_r.token_type = etok_pkg::TT_IDENT;
			end
			etok_pkg::M_ZERO, etok_pkg::M_INT, etok_pkg::M_FRAC,
			etok_pkg::M_EXP, etok_pkg::M_EXPD, etok_pkg::M_HEX: begin
				cl_r.token_type = etok_pkg::TT_NUMBER;
			end
			etok_pkg::M_DOT: begin
				cl_r.token_type   = etok_pkg::TT_OPER;
				cl_r.token_length = etok_pkg::POS_W'(1);
			end
			etok_pkg::M_OP: begin
				cl_r.token_type   = (held_q == etok_pkg::CH_EQ) ?
					etok_pkg::TT_EQUAL : etok_pkg::TT_OPER;
				cl_r.token_length = etok_pkg::POS_W'(1);
			end
			default: begin
				cl_v = 1'b0;
			end
		endcase
	end

	// Token opened by the current character
	always_comb begin
		bg_v    = 1'b0;
		bg_r    = etok_pkg::mk_word(etok_pkg::TT_OPER, pos_o, etok_pkg::POS_W'(1),
			etok_pkg::ERR_NONE, 1'b0);
		bg_mode = etok_pkg::M_IDLE;
		bg_beg  = pos_q;
		bg_held = held_q;
		if (etok_pkg::is_space(c)) begin
			bg_beg = beg_q;
		end else if (c == etok_pkg::CH_QUOTE) begin
			bg_mode = etok_pkg::M_STR;
		end else if (etok_pkg::is_digit(c)) begin
			bg_mode = (c == etok_pkg::CH_ZERO) ? etok_pkg::M_ZERO : etok_pkg::M_INT;
		end else if (c == etok_pkg::CH_DOT) begin
			bg_mode = etok_pkg::M_DOT;
		end else if (etok_pkg::is_id_start(c)) begin
			bg_mode = etok_pkg::M_IDENT;
		end else begin
			case (c)
				etok_pkg::CH_LPAREN: begin
					bg_v = 1'b1;
					bg_r.token_type = etok_pkg::TT_LPAREN;
				end
				etok_pkg::CH_RPAREN: begin
					bg_v = 1'b1;
					bg_r.token_type = etok_pkg::TT_RPAREN;
				end
				etok_pkg::CH_LBRACK: begin
					bg_v = 1'b1;
					bg_r.token_type = etok_pkg::TT_LBRACK;
				end
				etok_pkg::CH_RBRACK: begin
					bg_v = 1'b1;
					bg_r.token_type = etok_pkg::TT_RBRACK;
				end
				etok_pkg::CH_COMMA: begin
					bg_v = 1'b1;
					bg_r.token_type = etok_pkg::TT_COMMA;
				end
				etok_pkg::CH_COLON: begin
					bg_v = 1'b1;
					bg_r.token_type = etok_pkg::TT_COLON;
				end
				etok_pkg::CH_EQ, etok_pkg::CH_BANG, etok_pkg::CH_LT,
				etok_pkg::CH_GT, etok_pkg::CH_AMP, etok_pkg::CH_BAR: begin
					bg_held = c;
					bg_mode = etok_pkg::M_OP;
				end
				default: begin
					bg_v = 1'b1;
				end
			endcase
		end
	end

	// Mode update and result selection
	always_comb begin
		mode_d = mode_q;
		beg_d  = beg_q;
		pos_d  = pos_q;
		held_d = held_q;
		ovf_d  = ovf_q;
		a_v    = 1'b0;
		b_v    = 1'b0;
		a_r    = etok_pkg::mk_word(etok_pkg::TT_NUMBER, beg_o, len_incl,
			etok_pkg::ERR_NONE, 1'b0);
		b_r    = a_r;
		fall   = 1'b0;
		if (item.kind == etok_pkg::KIND_CHAR) begin
			if (ovf_q) begin
				// rest of an over-length line is dropped
			end else if (pos_q == LINE_MAX) begin
				ovf_d  = 1'b1;
				mode_d = etok_pkg::M_IDLE;
			end else begin
				pos_d = pos_q + PW'(1);
				case (mode_q)
					etok_pkg::M_STR: begin
						if (c == etok_pkg::CH_BSLASH) begin
							mode_d = etok_pkg::M_STRESC;
						end else if (c == etok_pkg::CH_QUOTE) begin
							a_v    = 1'b1;
							a_r.token_type = etok_pkg::TT_STRING;
							mode_d = etok_pkg::M_IDLE;
						end
					end
					etok_pkg::M_STRESC: begin
						mode_d = etok_pkg::M_STR;
					end
					etok_pkg::M_IDENT: begin
						fall = !etok_pkg::is_id_cont(c);
					end
					etok_pkg::M_ZERO, etok_pkg::M_INT: begin
						if (mode_q == etok_pkg::M_ZERO &&
								(c == etok_pkg::CH_LC_X || c == etok_pkg::CH_UC_X ||
								 c == etok_pkg::CH_LC_B || c == etok_pkg::CH_UC_B ||
								 c == etok_pkg::CH_LC_O || c == etok_pkg::CH_UC_O)) begin
							mode_d = etok_pkg::M_HEX;
						end else if (etok_pkg::is_digit(c)) begin
							mode_d = etok_pkg::M_INT;
						end else if (c == etok_pkg::CH_DOT) begin
							mode_d = etok_pkg::M_FRAC;
						end else if (c == etok_pkg::CH_LC_E || c == etok_pkg::CH_UC_E) begin
							mode_d = etok_pkg::M_EXP;
						end else if (c == etok_pkg::CH_LC_I) begin
							a_v    = 1'b1;
							mode_d = etok_pkg::M_IDLE;
						end else begin
							fall = 1'b1;
						end
					end
					etok_pkg::M_FRAC: begin
						if (etok_pkg::is_digit(c)) begin
							mode_d = etok_pkg::M_FRAC;
						end else if (c == etok_pkg::CH_LC_E || c == etok_pkg::CH_UC_E) begin
							mode_d = etok_pkg::M_EXP;
						end else if (c == etok_pkg::CH_LC_I) begin
							a_v    = 1'b1;
							mode_d = etok_pkg::M_IDLE;
						end else begin
							fall = 1'b1;
						end
					end
					etok_pkg::M_EXP: begin
						if (c == etok_pkg::CH_PLUS || c == etok_pkg::CH_MINUS ||
								etok_pkg::is_digit(c)) begin
							mode_d = etok_pkg::M_EXPD;
						end else if (c == etok_pkg::CH_LC_I) begin
							a_v    = 1'b1;
							mode_d = etok_pkg::M_IDLE;
						end else begin
							fall = 1'b1;
						end
					end
					etok_pkg::M_EXPD: begin
						if (c == etok_pkg::CH_LC_I) begin
							a_v    = 1'b1;
							mode_d = etok_pkg::M_IDLE;
						end else begin
							fall = !etok_pkg::is_digit(c);
						end
					end
					etok_pkg::M_HEX: begin
						fall = !etok_pkg::is_xdigit(c);
					end
					etok_pkg::M_DOT: begin
						if (etok_pkg::is_digit(c)) begin
							mode_d = etok_pkg::M_FRAC;
						end else begin
							fall = 1'b1;
						end
					end
					etok_pkg::M_OP: begin
						if ((c == etok_pkg::CH_EQ && (held_q == etok_pkg::CH_EQ ||
								held_q == etok_pkg::CH_BANG || held_q == etok_pkg::CH_LT ||
								held_q == etok_pkg::CH_GT)) ||
								(c == etok_pkg::CH_AMP && held_q == etok_pkg::CH_AMP) ||
								(c == etok_pkg::CH_BAR && held_q == etok_pkg::CH_BAR)) begin
							a_v    = 1'b1;
							a_r.token_type   = etok_pkg::TT_OPER;
							a_r.token_length = etok_pkg::POS_W'(2);
							mode_d = etok_pkg::M_IDLE;
						end else begin
							fall = 1'b1;
						end
					end
					default: begin
						fall = 1'b1;
					end
				endcase
				// close whatever is open, then start on this character
				if (fall) begin
					a_v    = cl_v;
					a_r    = cl_r;
					b_v    = bg_v;
					b_r    = bg_r;
					mode_d = bg_mode;
					beg_d  = bg_beg;
					held_d = bg_held;
				end
			end
		end else begin
			// end of line: error, or flush plus end word; line state starts afresh
			if (ovf_q) begin
				a_v = 1'b1;
				a_r = etok_pkg::mk_word(etok_pkg::TT_ERROR, '0, LEN_MAX_OUT,
					etok_pkg::ERR_TOOLONG, 1'b1);
			end else if (mode_q == etok_pkg::M_STR || mode_q == etok_pkg::M_STRESC) begin
				a_v = 1'b1;
				a_r = etok_pkg::mk_word(etok_pkg::TT_ERROR, beg_o, len_open,
					etok_pkg::ERR_UNTERM, 1'b1);
			end else begin
				a_v = cl_v;
				a_r = cl_r;
				b_v = 1'b1;
				b_r = etok_pkg::mk_word(etok_pkg::TT_END, pos_o, '0,
					etok_pkg::ERR_NONE, 1'b1);
			end
			mode_d = etok_pkg::M_IDLE;
			beg_d  = '0;
			pos_d  = '0;
			held_d = '0;
			ovf_d  = 1'b0;
		end
	end

	// Pack results in order and mark the last one
	always_comb begin
		res.w0 = a_v ? a_r : b_r;
		res.w1 = b_r;
		if (a_v && b_v) begin
			res.count = 2'd2;
			res.w1.run_last = 1'b1;
		end else begin
			res.count = (a_v || b_v) ? 2'd1 : 2'd0;
			res.w0.run_last = 1'b1;
		end
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= etok_pkg::M_IDLE;
			beg_q  <= '0;
			pos_q  <= '0;
			held_q <= '0;
			ovf_q  <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			beg_q  <= beg_d;
			pos_q  <= pos_d;
			held_q <= held_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

/* rtl/etok_outq.sv */
`timescale 1ns / 1ps
// Result queue: takes up to two words a cycle, hands out one word a cycle while token_ready is high.
module etok_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  etok_pkg::res_pair_t res,
	output logic                room,
	output logic                token_valid,
	input  logic                token_ready,
	output etok_pkg::out_word_t token
);

	localparam int AW = $clog2(etok_pkg::OUTQ_DEPTH);
	localparam int CW = $clog2(etok_pkg::OUTQ_DEPTH + 1);

	etok_pkg::out_word_t q_q [etok_pkg::OUTQ_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    push_n;
	logic          pop;

	assign push_n      = push ? res.count : 2'd0;
	assign pop         = token_valid && token_ready;
	assign token_valid = (cnt_q != '0);
	assign token       = q_q[rp_q];
	// space for a full pair whatever leaves this cycle
	assign room        = (cnt_q <= CW'(etok_pkg::OUTQ_DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_q[wp_q] <= res.w0;
		end
		if (push_n == 2'd2) begin
			q_q[wp_q + AW'(1)] <= res.w1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(push_n);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

/* rtl/expression_tokenizer.sv */
`timescale 1ns / 1ps
// Expression tokenizer top level: input register, scanner and result queue.
//
//  channel | signals                          | word
//  --------+----------------------------------+--------------------------------
//  item    | item_valid, item_ready, item     | kind, ch (one byte or end of line)
//  token   | token_valid, token_ready, token  | type, start, length, error, flags
//
// One word is taken per cycle while item_ready is high; a byte passes the input
// register before the queue. A word gives zero, one or two tokens; the queue drains
// one token per cycle while token_ready is high, which limits runs of two-token words.
// item_ready drops only when the four-entry result queue holds more than two tokens.
// Reset clears the line state, the input register and the queue.
module expression_tokenizer #(
	parameter int MAX_LINE_LEN = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  etok_pkg::in_word_t  item,
	output logic                token_valid,
	input  logic                token_ready,
	output etok_pkg::out_word_t token
);

	logic                valid_s1;
	etok_pkg::in_word_t  item_s1;
	logic                room;
	logic                adv;
	etok_pkg::res_pair_t res;

	assign adv        = valid_s1 && room;
	assign item_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	etok_lexer #(
		.MAX_LINE_LEN(MAX_LINE_LEN)
	) u_lexer (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (adv),
		.item  (item_s1),
		.res   (res)
	);

	etok_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (adv),
		.res        (res),
		.room       (room),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token      (token)
	);

endmodule

/* rtl/etok_check.sv */
`timescale 1ns / 1ps
// Port checker for the expression tokenizer, bound to the top level.
module etok_check (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input etok_pkg::in_word_t  item,
	input logic                token_valid,
	input logic                token_ready,
	input etok_pkg::out_word_t token
);

	// A stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token))
		else $error("token changed while stalled");

	// Error words carry a code and close the line
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.token_type == etok_pkg::TT_ERROR |->
			token.error_code != etok_pkg::ERR_NONE && token.line_done)
		else $error("error token without code or line end");

	// Ordinary tokens carry no error code
	a_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.token_type != etok_pkg::TT_ERROR |->
			token.error_code == etok_pkg::ERR_NONE)
		else $error("error code on ordinary token");

	// Only end and error words close a line, and they are the last of their run
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.line_done |->
			token.run_last && (token.token_type == etok_pkg::TT_END ||
			token.token_type == etok_pkg::TT_ERROR))
		else $error("bad line end token");

	// End word has no length and closes the line
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.token_type == etok_pkg::TT_END |->
			token.token_length == '0 && token.line_done)
		else $error("malformed end token");

endmodule

bind expression_tokenizer etok_check u_check (.*);
